FILE: rtl/r2a_pkg.sv
// ----------------------------------------------------------------------------
// r2a_pkg
// Shared types, widths and helpers for the radix to ASCII digit converter.
// ----------------------------------------------------------------------------
package r2a_pkg;

  localparam int VALUE_W      = 31;  // width of the number to convert
  localparam int RADIX_W      = 6;   // width of the radix register
  localparam int DIGIT_W      = 6;   // width of one stored digit value
  localparam int CHAR_W       = 7;   // width of one ASCII digit
  localparam int STEP_W       = 5;   // counts the divider's quotient bits
  localparam int RESULT_LIMIT = 31;  // most digits sent for one number

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;  // 'A'
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;

  // Request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [VALUE_W-1:0]   dividend;
    logic [RADIX_W-1:0]   divisor;
  } div_req_t;

  // Result from the shared divider
  typedef struct packed {
    logic                 done;
    logic [VALUE_W-1:0]   quot;
    logic [DIGIT_W-1:0]   rem;
  } div_rsp_t;

  // Clamp the radix register into the range 2 to 36
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_TEN) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_A + {1'b0, d - DIGIT_TEN};
    end
    return res;
  endfunction

endpackage

FILE: rtl/r2a_div.sv
// ----------------------------------------------------------------------------
// r2a_div
// Restoring divider, one quotient bit per cycle, for a 31-bit dividend and a
// radix divisor. Pulses done with quotient and remainder after 31 steps.
// ----------------------------------------------------------------------------
module r2a_div
  import r2a_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   cnt;
  logic [VALUE_W-1:0]  quot;
  logic [DIGIT_W-1:0]  rem;
  logic [RADIX_W-1:0]  dvs;

  logic [DIGIT_W:0]    trial;
  logic [DIGIT_W:0]    diff;
  logic                fits;

  // Bring down the next dividend bit and try one subtraction
  always_comb begin
    trial = {rem, quot[VALUE_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Control: step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift quotient bits in, keep the partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      quot <= {quot[VALUE_W-2:0], fits};
      rem  <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

FILE: rtl/r2a_digit_buf.sv
// ----------------------------------------------------------------------------
// r2a_digit_buf
// Digit store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module r2a_digit_buf
  import r2a_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DIGIT_W-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DIGIT_W-1:0]       rd_data
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  // Write one remainder
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one digit, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/radix_to_ascii_digits_unit.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit
// Converts a 31-bit number to ASCII digits in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the radix (6 bits). Values below 2
//   act as 2, values above 36 act as 36. Write it only while the unit idles.
//   s_axis carries one number per transfer in tdata[30:0]; s_axis_tready is
//   high only while the unit idles.
//   m_axis returns the digits most significant first, one per transfer, as
//   ASCII '0'-'9' and 'A'-'Z' in tdata[6:0]; tlast marks the final digit.
//   A zero input produces no output transfers.
// Flow:
//   Each digit costs one pass of the shared bit-serial divider over all 31
//   quotient bits. Output reads each digit from the buffer, then transfers
//   it. The next number is taken after the last digit transfer.
// Reset and stall:
//   rst (synchronous) sets the radix to 10 and returns the unit to idle.
//   A stalled receiver holds the current digit; the unit waits meanwhile.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits_unit
  import r2a_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,      // [5:0] radix
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [30:0] value, [31] zero fill
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [6:0] digit_char, [7] zero fill
  output logic        m_axis_tlast   // last_digit
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [RADIX_W-1:0]  radix;
  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    n_next;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    pos_next;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [DIGIT_W-1:0]  rd_data;
  logic [VALUE_W-1:0]  in_value;
  logic                in_xfer;
  logic                out_xfer;
  logic [CNT_W-1:0]    n_inc;
  logic                conv_end;

  assign in_value      = s_axis_tdata[VALUE_W-1:0];
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // Stop dividing once the quotient is zero or the buffer is full
  assign n_inc    = n + 1'b1;
  assign conv_end = (div_rsp.quot == '0) || (n_inc == CNT_W'(MAX_DIGITS));

  // Hold the radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  // Launch a division for a new number or for the last quotient
  always_comb begin
    div_req.divisor  = clamp_radix(radix);
    div_req.dividend = (state == ST_IDLE) ? in_value : div_rsp.quot;
    div_req.start    = ((state == ST_IDLE) && in_xfer && (in_value != '0)) ||
                       ((state == ST_DIV) && div_rsp.done && !conv_end);
  end

  r2a_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  r2a_digit_buf #(
    .DEPTH (MAX_DIGITS)
  ) u_buf (
    .clk     (clk),
    .wr_en   ((state == ST_DIV) && div_rsp.done),
    .wr_addr (n[IDX_W-1:0]),
    .wr_data (div_rsp.rem),
    .rd_en   (state == ST_RD),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  // Sequencer: divide, then read digits back from the top
  always_comb begin
    state_next = state;
    n_next     = n;
    pos_next   = pos;
    case (state)
      ST_IDLE: begin
        if (in_xfer && (in_value != '0)) begin
          n_next     = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          n_next = n_inc;
          if (conv_end) begin
            if (32'(n_inc) > RESULT_LIMIT) begin
              pos_next = IDX_W'(RESULT_LIMIT - 1);
            end else begin
              pos_next = IDX_W'(n);
            end
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) begin
          if (pos == '0) begin
            state_next = ST_IDLE;
          end else begin
            pos_next   = pos - 1'b1;
            state_next = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
  end

  // Drive the output digit
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {1'b0, digit_to_ascii(rd_data)};
  assign m_axis_tlast  = (pos == '0);

endmodule

FILE: tb/tb_radix_to_ascii_digits_unit.sv
// ----------------------------------------------------------------------------
// tb_radix_to_ascii_digits_unit
// Self-checking bench for the radix to ASCII digit converter. A queue-fed
// driver offers numbers on the input stream. A clocked monitor checks every
// digit transfer against digits predicted at input acceptance from a local
// copy of the radix. The run covers directed corner values, random numbers
// under several radix settings including the saturating ones, random
// idling on both sides, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_radix_to_ascii_digits_unit;
  import r2a_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 80;    // covers a zero number still in flight
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 8000;  // cycles with no transfer at all

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [30:0] value, [31] zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [6:0] digit_char, [7] zero fill
  logic        m_axis_tlast;        // last_digit

  logic [VALUE_W-1:0] values_pending [$];
  digit_t             digits_due [$];
  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 holds_asked = 0;
  int                 holds_served;
  int                 hold_left;
  int                 fail_count = 0;
  int                 quiet_cycles;

  radix_to_ascii_digits_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Append one number to the pending input queue
  function automatic void queue_value(input logic [VALUE_W-1:0] v);
    values_pending = {values_pending, v};
  endfunction

  // Convert one number and queue its digits, most significant first
  function automatic void predict_digits(input logic [VALUE_W-1:0] value);
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] rems [32];
    logic [VALUE_W-1:0] q;
    logic [DIGIT_W-1:0] d;
    digit_t             dig;
    int                 n;
    int                 emit;
    base = radix_reg;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    q = value;
    n = 0;
    while (q != 0 && n < 32) begin
      rems[n] = DIGIT_W'(q % base);
      q = q / base;
      n++;
    end
    emit = (n > RESULT_LIMIT) ? RESULT_LIMIT : n;
    for (int k = emit - 1; k >= 0; k--) begin
      d = rems[k];
      dig.ch = (d < DIGIT_TEN) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - DIGIT_TEN);
      dig.last = (k == 0);
      digits_due = {digits_due, dig};
    end
  endfunction

  // Mix of zero, tiny, full-range, power-of-two, near-maximum and shifted-down numbers
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(7))
      0: return '0;
      1: return VALUE_W'($urandom_range(1, 40));
      2, 3: return VALUE_W'($urandom);
      4: return VALUE_W'(1) << $urandom_range(30);
      5: return {VALUE_W{1'b1}} - VALUE_W'($urandom_range(255));
      default: return VALUE_W'($urandom) >> $urandom_range(1, 30);
    endcase
  endfunction

  // Wait until every number is taken and every digit is back, then settle
  task automatic drain_outputs();
    @(negedge clk);
    while (values_pending.size() != 0 || s_axis_tvalid || digits_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain_outputs();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    radix_reg = r;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 51; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 51; end
      default:   begin send_gap_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  task automatic run_phase(input logic [RADIX_W-1:0] r, input int count,
                           input idle_mode_t mode);
    write_radix(r);
    set_idling(mode);
    @(negedge clk);
    repeat (count) queue_value(random_value());
  endtask

  // Drive the input stream from the pending queue, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digits(s_axis_tdata[VALUE_W-1:0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (values_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, values_pending.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count down a requested receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // Check each digit transfer against the oldest predicted digit
  always @(posedge clk) begin : digit_monitor
    digit_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digits_due.size() == 0) begin
          $display("%0t: unexpected digit, expected none, actual char %0d last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = digits_due.pop_front();
          if (m_axis_tdata !== {1'b0, want.ch}) begin
            $display("%0t: digit char mismatch, expected %0d, actual %0d",
                     $time, {1'b0, want.ch}, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last flag mismatch, expected %0b, actual %0b",
                     $time, want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_radix_to_ascii_digits_unit: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: decimal extremes and a zero
    write_radix(6'd10);
    @(negedge clk);
    queue_value(31'd0);          queue_value(31'd1);
    queue_value(31'd9);          queue_value(31'd10);
    queue_value(31'h7FFF_FFFF);  queue_value(31'd1000000000);
    queue_value(31'd999999999);
    // Binary: longest digit string
    write_radix(6'd2);
    @(negedge clk);
    queue_value(31'd1);          queue_value(31'd2);
    queue_value(31'h7FFF_FFFF);  queue_value(31'h4000_0000);
    // Base 36: letters, digit roll-over and the largest number
    write_radix(6'd36);
    @(negedge clk);
    queue_value(31'd35);         queue_value(31'd36);
    queue_value(31'd1295);       queue_value(31'd1296);
    queue_value(31'h7FFF_FFFF);  queue_value(31'd0);
    // Radix below two and above thirty-six saturate
    write_radix(6'd0);
    @(negedge clk);
    queue_value(31'd5);
    write_radix(6'd63);
    @(negedge clk);
    queue_value(31'd35);

    // Random numbers under several settings and idling modes
    run_phase(6'd2,  40, IDLE_SEND);
    run_phase(6'd36, 40, IDLE_RECV);
    run_phase(6'd16, 40, IDLE_BOTH);
    run_phase(6'd10, 40, IDLE_NONE);
    run_phase(6'd0,  15, IDLE_BOTH);
    run_phase(6'd63, 15, IDLE_SEND);
    run_phase(6'd37, 15, IDLE_RECV);
    run_phase(6'd1,  15, IDLE_NONE);
    repeat (4) begin
      run_phase(RADIX_W'($urandom_range(63)), 15, idle_mode_t'($urandom_range(3)));
    end

    // Hold the receiver off while numbers keep coming
    run_phase(6'd10, 20, IDLE_NONE);
    holds_asked = holds_asked + 1;

    drain_outputs();
    if (fail_count == 0 && digits_due.size() == 0) begin
      $display("tb_radix_to_ascii_digits_unit: done, clean");
    end else begin
      $display("tb_radix_to_ascii_digits_unit: done, errors");
    end
    $finish;
  end

endmodule
